[rtl/core/afftx_pkg.sv]
package afftx_pkg;

    typedef struct packed {
        logic [1:0]         action;
        logic [1:0]         arg_count;
        logic signed [31:0] arg_a;
        logic signed [31:0] arg_b;
        logic signed [31:0] arg_c;
    } in_t;

    typedef struct packed {
        logic signed [31:0] m_a;
        logic signed [31:0] m_b;
        logic signed [31:0] m_c;
        logic signed [31:0] m_d;
        logic signed [31:0] m_e;
        logic signed [31:0] m_f;
        logic               saturated;
    } out_t;

    localparam logic [1:0] ACT_RESET     = 2'd0;
    localparam logic [1:0] ACT_TRANSLATE = 2'd1;
    localparam logic [1:0] ACT_SCALE     = 2'd2;
    localparam logic [1:0] ACT_ROTATE    = 2'd3;

    localparam logic [2:0] GRP_R  = 3'd0;
    localparam logic [2:0] GRP_U  = 3'd1;
    localparam logic [2:0] GRP_N0 = 3'd2;
    localparam logic [2:0] GRP_N1 = 3'd3;
    localparam logic [2:0] GRP_N2 = 3'd4;
    localparam logic [2:0] GRP_N3 = 3'd5;
    localparam logic [2:0] GRP_N4 = 3'd6;
    localparam logic [2:0] GRP_N5 = 3'd7;

    localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;
    localparam logic [31:0] GAIN_Q32    = 32'd2608131496;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MOD,
        OP_WRAP,
        OP_FOLDH,
        OP_FOLDQ,
        OP_RAD,
        OP_ITER,
        OP_SC,
        OP_COMMIT
    } op_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_INIT,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] idx;
        logic       mul_en;
        logic [3:0] sel;
        acc_op_t    acc_op;
        logic       store_en;
        logic [2:0] store_grp;
    } cmd_t;

    // Arctangent of 2^-i in Q32; from step 11 on it equals 2^(32-i).
    function automatic logic [33:0] atan_q32(input logic [4:0] i);
        logic [33:0] v;
        case (i)
            5'd0:    v = 34'h0C90FDAA2;
            5'd1:    v = 34'h076B19C16;
            5'd2:    v = 34'h03EB6EBF2;
            5'd3:    v = 34'h01FD5BA9B;
            5'd4:    v = 34'h00FFAADDC;
            5'd5:    v = 34'h007FF556F;
            5'd6:    v = 34'h003FFEAAB;
            5'd7:    v = 34'h001FFFD55;
            5'd8:    v = 34'h000FFFFAB;
            5'd9:    v = 34'h0007FFFF5;
            5'd10:   v = 34'h0003FFFFF;
            default: v = 34'd1 << (6'd32 - {1'b0, i});
        endcase
        return v;
    endfunction

endpackage

[rtl/core/afftx_ctrl.sv]
module afftx_ctrl #(
    parameter int FRAC_BITS         = 16,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        action,
    input  logic [1:0]        arg_count,
    output logic              m_valid,
    input  logic              m_ready,
    output afftx_pkg::cmd_t   cmd
);

    localparam int MOD_STEPS = (FRAC_BITS >= 24) ? 1 : 24 - FRAC_BITS;
    localparam logic [4:0] MOD_LAST  = 5'(MOD_STEPS - 1);
    localparam logic [4:0] ITER_LAST = 5'(CORDIC_ITERATIONS - 1);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_MOD   = 11'b00000000010,
        ST_WRAP  = 11'b00000000100,
        ST_FOLDH = 11'b00000001000,
        ST_FOLDQ = 11'b00000010000,
        ST_RAD   = 11'b00000100000,
        ST_ITER  = 11'b00001000000,
        ST_SC    = 11'b00010000000,
        ST_MAC   = 11'b00100000000,
        ST_LAST  = 11'b01000000000,
        ST_DONE  = 11'b10000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [2:0] grp_reg, grp_next;
    logic [1:0] ph_reg, ph_next;
    logic       pt_reg, pt_next;
    logic       out_valid_reg, out_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        grp_next       = grp_reg;
        ph_next        = ph_reg;
        pt_next        = pt_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd            = '0;
        cmd.op         = afftx_pkg::OP_NONE;
        cmd.acc_op     = afftx_pkg::ACC_HOLD;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op   = afftx_pkg::OP_LOAD;
                    pt_next  = (action == afftx_pkg::ACT_ROTATE) && (arg_count == 2'd3);
                    grp_next = afftx_pkg::GRP_N0;
                    ph_next  = 2'd0;
                    case (action)
                        afftx_pkg::ACT_RESET: state_next = ST_DONE;
                        afftx_pkg::ACT_ROTATE: begin
                            state_next = ST_MOD;
                            cnt_next   = MOD_LAST;
                        end
                        default: state_next = ST_MAC;
                    endcase
                end
            end
            ST_MOD: begin
                cmd.op  = afftx_pkg::OP_MOD;
                cmd.idx = cnt_reg;
                if (cnt_reg == 5'd0) begin
                    state_next = ST_WRAP;
                end else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            ST_WRAP: begin
                cmd.op     = afftx_pkg::OP_WRAP;
                state_next = ST_FOLDH;
            end
            ST_FOLDH: begin
                cmd.op     = afftx_pkg::OP_FOLDH;
                state_next = ST_FOLDQ;
            end
            ST_FOLDQ: begin
                cmd.op     = afftx_pkg::OP_FOLDQ;
                state_next = ST_RAD;
            end
            ST_RAD: begin
                cmd.op     = afftx_pkg::OP_RAD;
                cnt_next   = 5'd0;
                state_next = ST_ITER;
            end
            ST_ITER: begin
                cmd.op  = afftx_pkg::OP_ITER;
                cmd.idx = cnt_reg;
                if (cnt_reg == ITER_LAST) begin
                    state_next = ST_SC;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_SC: begin
                cmd.op     = afftx_pkg::OP_SC;
                grp_next   = pt_reg ? afftx_pkg::GRP_R : afftx_pkg::GRP_N0;
                ph_next    = 2'd0;
                state_next = ST_MAC;
            end
            ST_MAC: begin
                cmd.sel = {grp_reg, ph_reg[0]};
                case (ph_reg)
                    2'd0: begin
                        cmd.mul_en    = 1'b1;
                        cmd.acc_op    = afftx_pkg::ACC_INIT;
                        cmd.store_en  = (grp_reg != afftx_pkg::GRP_R) &&
                                        !(grp_reg == afftx_pkg::GRP_N0 && !pt_reg);
                        cmd.store_grp = grp_reg - 3'd1;
                        ph_next       = 2'd1;
                    end
                    2'd1: begin
                        cmd.mul_en = 1'b1;
                        cmd.acc_op = afftx_pkg::ACC_ADD;
                        ph_next    = 2'd2;
                    end
                    default: begin
                        cmd.acc_op = afftx_pkg::ACC_ADD;
                        ph_next    = 2'd0;
                        if (grp_reg == afftx_pkg::GRP_N5) begin
                            state_next = ST_LAST;
                        end else begin
                            grp_next = grp_reg + 3'd1;
                        end
                    end
                endcase
            end
            ST_LAST: begin
                cmd.store_en  = 1'b1;
                cmd.store_grp = afftx_pkg::GRP_N5;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.op         = afftx_pkg::OP_COMMIT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            grp_reg       <= '0;
            ph_reg        <= '0;
            pt_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            grp_reg       <= grp_next;
            ph_reg        <= ph_next;
            pt_reg        <= pt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/core/afftx_dp.sv]
module afftx_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  afftx_pkg::in_t   in_data,
    input  afftx_pkg::cmd_t  cmd,
    output afftx_pkg::out_t  out_data
);

    localparam int ACC_W = 65 - FRAC_BITS;
    localparam logic [32:0] FULL    = 33'(360) << FRAC_BITS;
    localparam logic [32:0] HALF    = 33'(180) << FRAC_BITS;
    localparam logic [32:0] QUARTER = 33'(90) << FRAC_BITS;
    localparam logic signed [31:0] ONE = 32'(64'd1 << FRAC_BITS);
    localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [35:0] CRND = 36'sd1 <<< (31 - FRAC_BITS);
    localparam logic signed [ACC_W-1:0] SMAX = ACC_W'(64'sh7FFFFFFF);
    localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);
    localparam logic [26:0] DEG2RAD_Q32_W = afftx_pkg::DEG2RAD_Q32;

    logic signed [31:0] m_reg [6];
    logic signed [31:0] n_reg [6];
    logic signed [31:0] p_reg, q_reg, r_reg, s_reg, t_reg, u_reg, b_reg, c_reg;
    logic               rst_act_reg, sat_reg, neg_reg, sneg_reg, cneg_reg;
    logic [32:0]        ip_reg, rr_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic signed [35:0] x_reg, y_reg, z_reg;
    logic signed [63:0] prod_reg;
    logic               prod_neg_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    afftx_pkg::out_t    out_reg;

    logic signed [31:0] ang, opa, opb, sat_val, cs, sn, cx, sx;
    logic [31:0]        mag;
    logic               opneg, over, under;
    logic [32:0]        mod_sub, remv;
    logic signed [63:0] prod_next, prod_rnd, rp_full;
    logic [63:0]        radp;
    logic signed [35:0] dx, dy, at, cxw, sxw;

    assign out_data = out_reg;

    always_comb begin
        ang     = (in_data.arg_count != 2'd0) ? in_data.arg_a : 32'sd0;
        mag     = ang[31] ? (~ang + 32'd1) : ang;
        mod_sub = 33'(360) << cmd.idx;
        remv    = (ip_reg << FRAC_BITS) | 33'(frac_reg);
        radp    = 64'(rr_reg[30:0]) * 64'(DEG2RAD_Q32_W);
        dx      = y_reg >>> cmd.idx;
        dy      = x_reg >>> cmd.idx;
        at      = $signed({2'b00, afftx_pkg::atan_q32(cmd.idx)});
        cxw     = (x_reg + CRND) >>> (32 - FRAC_BITS);
        sxw     = (y_reg + CRND) >>> (32 - FRAC_BITS);
        cx      = cxw[31:0];
        sx      = sxw[31:0];
        cs      = cneg_reg ? -cx : cx;
        sn      = sneg_reg ? -sx : sx;
    end

    always_comb begin
        opneg = 1'b0;
        case (cmd.sel)
            4'd0:    begin opa = p_reg;    opb = b_reg; opneg = 1'b1; end
            4'd1:    begin opa = s_reg;    opb = c_reg; end
            4'd2:    begin opa = s_reg;    opb = b_reg; opneg = 1'b1; end
            4'd3:    begin opa = p_reg;    opb = c_reg; opneg = 1'b1; end
            4'd4:    begin opa = m_reg[0]; opb = p_reg; end
            4'd5:    begin opa = m_reg[1]; opb = s_reg; end
            4'd6:    begin opa = m_reg[0]; opb = q_reg; end
            4'd7:    begin opa = m_reg[1]; opb = t_reg; end
            4'd8:    begin opa = m_reg[0]; opb = r_reg; end
            4'd9:    begin opa = m_reg[1]; opb = u_reg; end
            4'd10:   begin opa = m_reg[3]; opb = p_reg; end
            4'd11:   begin opa = m_reg[4]; opb = s_reg; end
            4'd12:   begin opa = m_reg[3]; opb = q_reg; end
            4'd13:   begin opa = m_reg[4]; opb = t_reg; end
            4'd14:   begin opa = m_reg[3]; opb = r_reg; end
            default: begin opa = m_reg[4]; opb = u_reg; end
        endcase
        prod_next = opa * opb;
        prod_rnd  = prod_reg + RND;
        rp_full   = prod_rnd >>> FRAC_BITS;
    end

    always_comb begin
        acc_next = acc_reg;
        case (cmd.acc_op)
            afftx_pkg::ACC_INIT: begin
                case (cmd.sel[3:1])
                    afftx_pkg::GRP_R:  acc_next = ACC_W'(b_reg);
                    afftx_pkg::GRP_U:  acc_next = ACC_W'(c_reg);
                    afftx_pkg::GRP_N2: acc_next = ACC_W'(m_reg[2]);
                    afftx_pkg::GRP_N5: acc_next = ACC_W'(m_reg[5]);
                    default:           acc_next = '0;
                endcase
            end
            afftx_pkg::ACC_ADD: begin
                acc_next = prod_neg_reg ? acc_reg - rp_full[ACC_W-1:0]
                                        : acc_reg + rp_full[ACC_W-1:0];
            end
            default: acc_next = acc_reg;
        endcase
        over  = acc_reg > SMAX;
        under = acc_reg < SMIN;
        if (over) begin
            sat_val = 32'sh7FFFFFFF;
        end else if (under) begin
            sat_val = 32'sh80000000;
        end else begin
            sat_val = acc_reg[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_reg[0] <= ONE;
            m_reg[1] <= '0;
            m_reg[2] <= '0;
            m_reg[3] <= '0;
            m_reg[4] <= ONE;
            m_reg[5] <= '0;
        end else if (cmd.op == afftx_pkg::OP_COMMIT) begin
            if (rst_act_reg) begin
                m_reg[0] <= ONE;
                m_reg[1] <= '0;
                m_reg[2] <= '0;
                m_reg[3] <= '0;
                m_reg[4] <= ONE;
                m_reg[5] <= '0;
            end else begin
                m_reg <= n_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (cmd.mul_en) begin
            prod_reg     <= prod_next;
            prod_neg_reg <= opneg;
        end
        if (cmd.store_en) begin
            sat_reg <= sat_reg | over | under;
            case (cmd.store_grp)
                afftx_pkg::GRP_R:  r_reg    <= sat_val;
                afftx_pkg::GRP_U:  u_reg    <= sat_val;
                afftx_pkg::GRP_N0: n_reg[0] <= sat_val;
                afftx_pkg::GRP_N1: n_reg[1] <= sat_val;
                afftx_pkg::GRP_N2: n_reg[2] <= sat_val;
                afftx_pkg::GRP_N3: n_reg[3] <= sat_val;
                afftx_pkg::GRP_N4: n_reg[4] <= sat_val;
                default:           n_reg[5] <= sat_val;
            endcase
        end
        case (cmd.op)
            afftx_pkg::OP_LOAD: begin
                rst_act_reg <= (in_data.action == afftx_pkg::ACT_RESET);
                sat_reg     <= 1'b0;
                b_reg       <= in_data.arg_b;
                c_reg       <= in_data.arg_c;
                neg_reg     <= ang[31];
                ip_reg      <= 33'(mag >> FRAC_BITS);
                frac_reg    <= mag[FRAC_BITS-1:0];
                sneg_reg    <= 1'b0;
                cneg_reg    <= 1'b0;
                q_reg       <= '0;
                s_reg       <= '0;
                r_reg       <= (in_data.action == afftx_pkg::ACT_TRANSLATE &&
                                in_data.arg_count > 2'd0) ? in_data.arg_a : 32'sd0;
                u_reg       <= (in_data.action == afftx_pkg::ACT_TRANSLATE &&
                                in_data.arg_count > 2'd1) ? in_data.arg_b : 32'sd0;
                p_reg       <= (in_data.action == afftx_pkg::ACT_SCALE &&
                                in_data.arg_count > 2'd0) ? in_data.arg_a : ONE;
                t_reg       <= (in_data.action != afftx_pkg::ACT_SCALE) ? ONE :
                               (in_data.arg_count > 2'd1) ? in_data.arg_b :
                               (in_data.arg_count > 2'd0) ? in_data.arg_a : ONE;
            end
            afftx_pkg::OP_MOD: begin
                if (ip_reg >= mod_sub) begin
                    ip_reg <= ip_reg - mod_sub;
                end
            end
            afftx_pkg::OP_WRAP: begin
                rr_reg <= (neg_reg && remv != 33'd0) ? FULL - remv : remv;
            end
            afftx_pkg::OP_FOLDH: begin
                if (rr_reg > HALF) begin
                    rr_reg   <= FULL - rr_reg;
                    sneg_reg <= 1'b1;
                end
            end
            afftx_pkg::OP_FOLDQ: begin
                if (rr_reg > QUARTER) begin
                    rr_reg   <= HALF - rr_reg;
                    cneg_reg <= 1'b1;
                end
            end
            afftx_pkg::OP_RAD: begin
                z_reg <= $signed(36'(radp >> FRAC_BITS));
                x_reg <= $signed(36'(afftx_pkg::GAIN_Q32));
                y_reg <= '0;
            end
            afftx_pkg::OP_ITER: begin
                if (!z_reg[35]) begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end else begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
            end
            afftx_pkg::OP_SC: begin
                p_reg <= cs;
                q_reg <= -sn;
                s_reg <= sn;
                t_reg <= cs;
            end
            afftx_pkg::OP_COMMIT: begin
                if (rst_act_reg) begin
                    out_reg <= {ONE, 32'sd0, 32'sd0, 32'sd0, ONE, 32'sd0, 1'b0};
                end else begin
                    out_reg <= {n_reg[0], n_reg[1], n_reg[2], n_reg[3], n_reg[4], n_reg[5],
                                sat_reg};
                end
            end
            default: ;
        endcase
    end

endmodule

[rtl/core/affine_transform_accumulator_core.sv]
// From acceptance, a reset request goes straight to commit; translate and scale run the
// multiply-accumulate groups; a rotation first runs the angle reduction, the CORDIC loop
// and the sine/cosine load, then the groups, with two more groups about a point.
// One request is in flight at a time; the next is accepted from the cycle in which the
// result appears. The commit waits while an earlier result is held unaccepted; the time
// is set by the angle reduction, the CORDIC loop and the single shared 32 x 32 multiplier.
// Reset is synchronous and active low; it sets the running matrix to identity.
module affine_transform_accumulator_core #(
    parameter int FRAC_BITS         = 16,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  afftx_pkg::in_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output afftx_pkg::out_t  m_data
);

    afftx_pkg::cmd_t cmd;

    afftx_ctrl #(
        .FRAC_BITS(FRAC_BITS),
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_ctrl (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .action(s_data.action),
        .arg_count(s_data.arg_count),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cmd(cmd)
    );

    afftx_dp #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .aclk(aclk),
        .aresetn(aresetn),
        .in_data(s_data),
        .cmd(cmd),
        .out_data(m_data)
    );

    a_reset_clears_valid: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid set after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("new request accepted while busy");

    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a request in progress");

endmodule
